// ===== design/binary_neighbor_count_3x3_top_macros.svh =====
// assertion macros for the binary 3x3 neighbour count block
`ifndef BINARY_NEIGHBOR_COUNT_3X3_TOP_MACROS_SVH
`define BINARY_NEIGHBOR_COUNT_3X3_TOP_MACROS_SVH

// same-cycle implication
`define BNC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bnc_pkg.sv =====
// shared types, constants and functions of the binary 3x3 neighbour count block
`default_nettype none

package bnc_pkg;

   localparam int unsigned MAX_COLS_DEF = 64;
   localparam int unsigned MAX_ROWS_DEF = 64;

   localparam int unsigned CFG_W     = 7;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned COUNT_W   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 2'd1;

   localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

   typedef struct packed {
      logic [COUNT_W-1:0] box_count;
      logic               frame_end;
   } res_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_status_type;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned max_dim);
      int unsigned vv;
      vv = int'(v);
      if (vv < 1) begin
         return 1;
      end
      if (vv > max_dim) begin
         return max_dim;
      end
      return vv;
   endfunction

   function automatic logic [COUNT_W-1:0] ones9(logic [8:0] w);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < 9; i++) begin
         n = n + COUNT_W'(w[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== design/bnc_line_store.sv =====
// two-row line store: one write and one registered read per cycle, with write bypass
`default_nettype none

module bnc_line_store #(
   parameter int unsigned MAX_COLS = 64,
   localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [CW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data,
   input  wire logic [CW-1:0] rd_addr,
   output logic [1:0]         rd_data_ff
);

   // bit 1: row two above the input, bit 0: row just above
   logic [1:0] store_ff [MAX_COLS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/bnc_window.sv =====
// position counters, 3x3 window and box count of the neighbour count block
`default_nettype none

module bnc_window #(
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned MAX_ROWS = 64,
   localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int unsigned CCW = CW + 1,
   localparam int unsigned RW  = $clog2(MAX_ROWS + 2)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             cell_set,
   input  wire logic             is_pad,
   input  wire logic [RW-1:0]    rows_eff,
   input  wire logic [CCW-1:0]   cols_eff,
   input  wire logic [1:0]       rd_data,
   output logic                  wr_en,
   output logic [CW-1:0]         wr_addr,
   output logic [1:0]            wr_data,
   output logic [CW-1:0]         rd_addr,
   output logic                  res_valid,
   output bnc_pkg::res_type      res,
   output logic                  flush
);

   import bnc_pkg::*;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [8:0]    win_ff, win_in;
   logic          has_top, has_mid, in_frame;
   logic          top, mid, bot;
   logic [2:0]    col3;
   logic [8:0]    shifted;

   always_comb begin
      flush    = row_ff > rows_eff;
      has_top  = row_ff >= RW'(2);
      has_mid  = row_ff != '0;
      in_frame = row_ff < rows_eff;
      top      = has_top & rd_data[1];
      mid      = has_mid & rd_data[0];
      bot      = in_frame & ~is_pad & cell_set;
      col3     = {bot, mid, top};
      shifted  = {col3, win_ff[8:3]};

      win_in        = win_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      res_valid     = 1'b0;
      res.box_count = ones9({3'b000, win_ff[8:3]});
      res.frame_end = 1'b0;
      wr_en         = 1'b0;

      if (step) begin
         if (flush) begin
            // closing item: last cell, nothing to its right
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            win_in        = '0;
            row_in        = '0;
            col_in        = '0;
         end else begin
            wr_en = 1'b1;
            if (col_ff == '0) begin
               // previous row's last cell completes here
               res_valid = has_top;
               win_in    = {col3, 6'b000000};
            end else begin
               res_valid     = has_mid;
               res.box_count = ones9(shifted);
               win_in        = shifted;
            end
            if (({1'b0, col_ff} + CCW'(1)) >= cols_eff) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   assign wr_addr = col_ff;
   assign wr_data = {rd_data[0], bot};
   assign rd_addr = col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         win_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bnc_out_buf.sv =====
// two-entry result buffer: output register plus skid register
`default_nettype none

module bnc_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bnc_pkg::res_type    push_data,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output bnc_pkg::res_type         rsp_data,
   output logic                     space,
   output bnc_pkg::buf_status_type  status
);

   import bnc_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type main_ff, main_in;
   res_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = main_valid_ff;
   assign rsp_data          = main_ff;
   assign space             = ~skid_valid_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

`default_nettype wire

// ===== design/binary_neighbor_count_3x3_top.sv =====
// top level of the streaming binary 3x3 neighbour count block
//
//   channel   direction   ports                               role
//   req_      in          req_cell_set, req_is_pad            one grid cell per transfer
//   rsp_      out         rsp_box_count, rsp_frame_end        one neighbour count per transfer
//   csr_      in          csr_index, csr_wdata                grid_rows / grid_cols writes
//
// one cell is taken every clock while req_ready is high; a result is registered into the output
// or skid register from the transfer that completes it, one row plus one cell behind its own cell
// the rate is set by the dual-port line store: one write and one registered read
// per cycle, the read address running one cell ahead of the input position
// synchronous reset clears the counters, window and buffer valids; the line store
// needs no clearing, its entries are masked by the row counter until written
// a stalled result sits in the output register while the skid register takes one more;
// req_ready drops only when both hold results
`default_nettype none
`include "binary_neighbor_count_3x3_top_macros.svh"

module binary_neighbor_count_3x3_top #(
   parameter int unsigned MAX_COLS = bnc_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS = bnc_pkg::MAX_ROWS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // cell input
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cell_set,
   input  wire logic                           req_is_pad,
   // result output
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bnc_pkg::COUNT_W-1:0]         rsp_box_count,
   output logic                                rsp_frame_end,
   // register writes
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bnc_pkg::CFG_W-1:0]      csr_wdata
);

   import bnc_pkg::*;

   localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned CCW = CW + 1;
   localparam int unsigned RW  = $clog2(MAX_ROWS + 2);

   // configuration registers
   logic [CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0] grid_cols_ff, grid_cols_in;

   // effective frame size after clamping
   logic [RW-1:0]  rows_eff;
   logic [CCW-1:0] cols_eff;

   logic           req_xfer;
   logic           store_wr_en;
   logic [CW-1:0]  store_wr_addr;
   logic [1:0]     store_wr_data;
   logic [CW-1:0]  store_rd_addr;
   logic [1:0]     store_rd_data;
   logic           res_valid;
   res_type        res;
   res_type        rsp_data;
   logic           win_flush;
   logic           buf_space;
   buf_status_type buf_status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_valid) begin
         if (csr_index == REG_GRID_ROWS) begin
            grid_rows_in = csr_wdata;
         end else if (csr_index == REG_GRID_COLS) begin
            grid_cols_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_DIM_RESET;
         grid_cols_ff <= GRID_DIM_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   assign rows_eff = RW'(clamp_dim(grid_rows_ff, MAX_ROWS));
   assign cols_eff = CCW'(clamp_dim(grid_cols_ff, MAX_COLS));

   // an input transfer needs room in the skid register only
   assign req_ready = buf_space;
   assign req_xfer  = req_valid & req_ready;

   bnc_line_store #(
      .MAX_COLS (MAX_COLS)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (store_wr_en),
      .wr_addr    (store_wr_addr),
      .wr_data    (store_wr_data),
      .rd_addr    (store_rd_addr),
      .rd_data_ff (store_rd_data)
   );

   bnc_window #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (req_xfer),
      .cell_set  (req_cell_set),
      .is_pad    (req_is_pad),
      .rows_eff  (rows_eff),
      .cols_eff  (cols_eff),
      .rd_data   (store_rd_data),
      .wr_en     (store_wr_en),
      .wr_addr   (store_wr_addr),
      .wr_data   (store_wr_data),
      .rd_addr   (store_rd_addr),
      .res_valid (res_valid),
      .res       (res),
      .flush     (win_flush)
   );

   bnc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (buf_space),
      .status    (buf_status)
   );

   assign rsp_box_count = rsp_data.box_count;
   assign rsp_frame_end = rsp_data.frame_end;

   // skid register is only filled behind a held output register
   `BNC_ASSERT_SAME(a_skid_behind_main, clock, reset, buf_status.skid_valid, buf_status.main_valid, "skid register holds a result while output register is empty")
   // input stalls only while a result is on offer
   `BNC_ASSERT_SAME(a_stall_needs_result, clock, reset, !req_ready, rsp_valid, "input stalled with no result pending")
   // the closing transfer of a frame always leaves a result behind
   `BNC_ASSERT_NEXT(a_flush_gives_result, clock, reset, req_xfer && win_flush, rsp_valid, "frame closing transfer produced no result")

endmodule

`default_nettype wire

// ===== tb/box_count_checker.sv =====
// checker that predicts and compares the neighbour counts of the 3x3 box sum block
`timescale 1ns / 100ps

module box_count_checker #(
   parameter int unsigned MAX_COLS = bnc_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS = bnc_pkg::MAX_ROWS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          req_cell_set,
   input  wire logic                          req_is_pad,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [bnc_pkg::COUNT_W-1:0]   rsp_box_count,
   input  wire logic                          rsp_frame_end,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [bnc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bnc_pkg::CFG_W-1:0]     csr_wdata,
   output int unsigned                        fail_count,
   output int unsigned                        outstanding,
   output int unsigned                        counts_checked
);
   import bnc_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   logic              older_row [MAX_COLS];
   logic              newer_row [MAX_COLS];
   logic [8:0]        box;
   int unsigned       row_at;
   int unsigned       col_at;
   logic [CFG_W-1:0]  rows_cfg;
   logic [CFG_W-1:0]  cols_cfg;
   res_type           pending_counts [$];
   int unsigned       bad;
   int unsigned       seen;

   function automatic void queue_count(input logic [8:0] bits, input logic last);
      res_type item;
      item.box_count = COUNT_W'($countones(bits));
      item.frame_end = last;
      pending_counts.push_back(item);
   endfunction

   // one accepted cell: shift the window and queue the counts it completes
   task automatic advance_box_sums(input logic cell_bit, input logic pad);
      int unsigned n_rows;
      int unsigned n_cols;
      int unsigned r;
      int unsigned c;
      logic        top_b;
      logic        mid_b;
      logic        bot_b;
      n_rows = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg);
      n_cols = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg);
      r = row_at;
      c = col_at;
      if (r > n_rows) begin
         // past the pad row: the last cell has no right-hand column
         queue_count(box >> 3, 1'b1);
         box    = '0;
         row_at = 0;
         col_at = 0;
      end else begin
         if (c >= MAX_COLS) begin
            c = 0;
         end
         top_b = (r >= 2 && r - 2 < n_rows) ? older_row[c] : 1'b0;
         mid_b = (r >= 1 && r - 1 < n_rows) ? newer_row[c] : 1'b0;
         bot_b = (r < n_rows && !pad) ? cell_bit : 1'b0;
         older_row[c] = newer_row[c];
         newer_row[c] = bot_b;
         if (c == 0) begin
            if (r >= 2) begin
               queue_count(box >> 3, 1'b0);
            end
            box = {bot_b, mid_b, top_b, 6'b0};
         end else begin
            box = {bot_b, mid_b, top_b, box[8:3]};
            if (r >= 1) begin
               queue_count(box, 1'b0);
            end
         end
         if (c + 1 >= n_cols) begin
            col_at = 0;
            row_at = r + 1;
         end else begin
            col_at = c + 1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      res_type want;
      if (reset) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            older_row[i] = 1'b0;
            newer_row[i] = 1'b0;
         end
         box      = '0;
         row_at   = 0;
         col_at   = 0;
         rows_cfg = GRID_DIM_RESET;
         cols_cfg = GRID_DIM_RESET;
         pending_counts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GRID_ROWS) begin
               rows_cfg = csr_wdata;
            end else if (csr_index == REG_GRID_COLS) begin
               cols_cfg = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (pending_counts.size() == 0) begin
               if (bad < REPORT_LIMIT) begin
                  $display("unexpected result: count %0d end %0b", rsp_box_count, rsp_frame_end);
               end
               bad++;
            end else begin
               want = pending_counts.pop_front();
               if (want.box_count !== rsp_box_count || want.frame_end !== rsp_frame_end) begin
                  if (bad < REPORT_LIMIT) begin
                     $display("result %0d wrong: expected count %0d end %0b, got count %0d end %0b",
                              seen, want.box_count, want.frame_end, rsp_box_count, rsp_frame_end);
                  end
                  bad++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_box_sums(req_cell_set, req_is_pad);
         end
      end
      fail_count     <= bad;
      outstanding    <= pending_counts.size();
      counts_checked <= seen;
   end

endmodule

// ===== tb/tb.sv =====
// stimulus and verdict for the binary 3x3 neighbour count block
`timescale 1ns / 100ps

module tb;
   import bnc_pkg::*;

   localparam int unsigned ITEM_TARGET    = 1650;
   localparam int unsigned PHASE_ITEMS    = 550;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned STALL_LIMIT    = 4000;
   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_cell_set;
   logic                 req_is_pad;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COUNT_W-1:0]   rsp_box_count;
   logic                 rsp_frame_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned counts_checked;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        holdoff_req;
   int unsigned items_sent;
   int unsigned reg_writes;
   int unsigned grids_tried;
   int unsigned quiet_cycles;

   binary_neighbor_count_3x3_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_set  (req_cell_set),
      .req_is_pad    (req_is_pad),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_box_count (rsp_box_count),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   box_count_checker count_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_set   (req_cell_set),
      .req_is_pad     (req_is_pad),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_box_count  (rsp_box_count),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .counts_checked (counts_checked)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // a register value of zero means one, anything above the maximum means the maximum
   function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] raw,
                                              input int unsigned max_dim);
      if (raw == 0) begin
         return 1;
      end
      return (raw > max_dim) ? max_dim : raw;
   endfunction

   // sender idling set at once in the stimulus process, receiver idling through a nonblocking assignment
   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // one cell transfer, with random idle cycles ahead of it
   task automatic offer_cell(input logic cell_bit, input logic pad);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cell_set <= cell_bit;
      req_is_pad   <= pad;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // valid is left high; the caller lowers it once the writes are done
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      reg_writes++;
   endtask

   // sender stops until every count is back, then waits out the settle time for a cell
   // that is still in flight without a result of its own
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_grid(input logic [CFG_W-1:0] rows_val,
                                 input logic [CFG_W-1:0] cols_val);
      wait_for_drain();
      write_reg(REG_GRID_ROWS, rows_val);
      write_reg(REG_GRID_COLS, cols_val);
      csr_valid <= 1'b0;
      grids_tried++;
   endtask

   // a whole frame: cells, then a pad row and the closing item
   task automatic send_frame(input int unsigned n_rows, input int unsigned n_cols,
                             input bit noisy);
      int unsigned density;
      int unsigned k;
      density = $urandom_range(100);
      for (k = 0; k < n_rows * n_cols; k++) begin
         offer_cell($urandom_range(99) < density, noisy && ($urandom_range(7) == 0));
      end
      // noisy frames put cell data and cleared pad flags into the flush region
      for (k = 0; k <= n_cols; k++) begin
         offer_cell(noisy ? ($urandom_range(1) == 1) : 1'b0,
                    noisy ? ($urandom_range(1) == 1) : 1'b1);
      end
   endtask

   // receiver: random ready, plus one long hold-off counted here
   initial begin : receiver
      logic held_once;
      held_once = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req && !held_once) begin
            held_once = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: too long without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles, %0d counts still due", STALL_LIMIT, outstanding);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] rows_val;
      logic [CFG_W-1:0] cols_val;
      int unsigned      pick;
      int unsigned      groups;
      int unsigned      g;
      int unsigned      k;
      bit               start_holdoff;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cell_set <= 1'b0;
      req_is_pad   <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= REG_GRID_ROWS;
      csr_wdata    <= '0;
      holdoff_req  <= 1'b0;
      items_sent   = 0;
      reg_writes   = 0;
      grids_tried  = 0;
      set_idling(0, 0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(23, 83);

      // writes to unused indexes must leave the grid alone
      write_reg(REG_SPARE_A, 7'h55);
      write_reg(REG_SPARE_B, 7'h2a);
      write_reg(REG_GRID_ROWS, 7'd3);
      write_reg(REG_GRID_COLS, 7'd3);
      csr_valid <= 1'b0;
      grids_tried++;

      // full 3x3 grid: centre count of nine; flush items carry data without the pad flag
      for (k = 0; k < 9; k++) begin
         offer_cell(1'b1, 1'b0);
      end
      for (k = 0; k < 4; k++) begin
         offer_cell(1'b1, 1'b0);
      end

      // zero in both registers means a 1x1 grid; its only cell is padded to zero
      configure_grid(7'd0, 7'd0);
      offer_cell(1'b1, 1'b1);
      offer_cell(1'b0, 1'b1);
      offer_cell(1'b1, 1'b1);

      // rows above the maximum act as 64; cut the frame short by lowering the row count
      configure_grid(7'd127, 7'd2);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b0, 1'b0);
      offer_cell(1'b1, 1'b1);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b0, 1'b0);
      offer_cell(1'b1, 1'b0);
      wait_for_drain();
      write_reg(REG_GRID_ROWS, 7'd1);
      csr_valid <= 1'b0;
      offer_cell(1'b1, 1'b0);

      // random frames, mostly small, a few tall, wide or out of range
      start_holdoff = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 2 * PHASE_ITEMS) begin
            set_idling(0, 0);
         end else if (items_sent >= PHASE_ITEMS) begin
            set_idling(83, 23);
         end
         pick = $urandom_range(99);
         if (!start_holdoff && items_sent >= 2 * PHASE_ITEMS) begin
            // big enough to fill the block while the receiver holds off
            start_holdoff = 1'b1;
            rows_val = 7'd8;
            cols_val = 7'd8;
         end else if (pick < 65) begin
            rows_val = CFG_W'($urandom_range(1, 6));
            cols_val = CFG_W'($urandom_range(1, 8));
         end else if (pick < 75) begin
            rows_val = CFG_W'($urandom_range(7, 64));
            cols_val = CFG_W'($urandom_range(1, 3));
         end else if (pick < 83) begin
            rows_val = CFG_W'($urandom_range(1, 3));
            cols_val = CFG_W'($urandom_range(9, 64));
         end else if (pick < 91) begin
            if ($urandom_range(1) == 1) begin
               rows_val = ($urandom_range(1) == 1) ? '0 : CFG_W'($urandom_range(65, 127));
               cols_val = CFG_W'($urandom_range(3));
            end else begin
               cols_val = ($urandom_range(1) == 1) ? '0 : CFG_W'($urandom_range(65, 127));
               rows_val = CFG_W'($urandom_range(2));
            end
         end else begin
            if ($urandom_range(1) == 1) begin
               rows_val = 7'd64;
               cols_val = CFG_W'($urandom_range(1, 2));
            end else begin
               rows_val = CFG_W'($urandom_range(1, 2));
               cols_val = 7'd64;
            end
         end
         configure_grid(rows_val, cols_val);
         if (start_holdoff) begin
            holdoff_req <= 1'b1;
         end
         groups = (pick < 65) ? $urandom_range(1, 3) : 1;
         for (g = 0; g < groups; g++) begin
            send_frame(dim_in_use(rows_val, MAX_ROWS_DEF), dim_in_use(cols_val, MAX_COLS_DEF),
                       $urandom_range(99) < 20);
         end
      end

      wait_for_drain();
      $display("sent %0d cells over %0d grid settings, %0d register writes",
               items_sent, grids_tried, reg_writes);
      $display("compared %0d neighbour counts, %0d failures", counts_checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
